// File: rtl/contiguous_page_allocator_defines.svh
// Assertion macros for the contiguous page allocator checker.
// No dependencies; included by the checker file only.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CPA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define CPA_ASSERT_NEXT_NR(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/cpa_pkg.sv
// Shared types, codes and defaults of the contiguous page allocator.
// No dependencies; used by every module of the block but cpa_ram.
`default_nettype none

package cpa_pkg;

   localparam int TOTAL_FRAMES_DEFAULT = 1024;
   localparam int CMD_QUEUE_DEPTH      = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOSPACE  = 2'd1;
   localparam logic [1:0] ST_NOTALLOC = 2'd2;
   localparam logic [1:0] ST_RESERVED = 2'd3;

   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_FREE   = 2'd1;
   localparam logic [1:0] CMD_REJECT = 2'd2;

   localparam logic [10:0] USED_MAX = 11'd2047;

   typedef struct packed {
      logic [2:0]  pad;
      logic [15:0] owner_id;
      logic [9:0]  page_index;
      logic [10:0] page_count;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  pad;
      logic [10:0] used_pages;
      logic [9:0]  first_frame;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [10:0] page_count;
      logic [9:0]  page_index;
      logic [15:0] owner_id;
   } cmd_type;

   typedef struct packed {
      logic [15:0] owner_id;
      logic [10:0] run_length;
      logic        taken;
   } frame_type;

endpackage

`default_nettype wire

// File: rtl/cpa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the frame map of the allocator.
`default_nettype none

module cpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: rtl/cpa_cmd_queue.sv
// Short command queue between the front and back parts of the allocator.
// Depends on cpa_pkg for the command type and depth.
`default_nettype none

module cpa_cmd_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire cpa_pkg::cmd_type push_cmd,
   input  wire logic            pop,
   output cpa_pkg::cmd_type     head,
   output logic                 full,
   output logic                 empty
);

   localparam int DEPTH = cpa_pkg::CMD_QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   cpa_pkg::cmd_type mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    fill_ff, fill_in;

   assign full  = (fill_ff == CW'(DEPTH));
   assign empty = (fill_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: rtl/cpa_front.sv
// Front part: accepts request beats and classifies them into commands.
// Depends on cpa_pkg for payload layout, codes and the command type.
`default_nettype none

module cpa_front #(
   parameter int TOTAL_FRAMES = cpa_pkg::TOTAL_FRAMES_DEFAULT
) (
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [39:0]      req_tdata,
   input  wire logic             req_tuser,
   input  wire logic [10:0]      boundary,
   input  wire logic             clearing,
   input  wire logic             queue_full,
   output logic                  push,
   output cpa_pkg::cmd_type      push_cmd
);

   cpa_pkg::req_payload_type payload;

   assign payload    = cpa_pkg::req_payload_type'(req_tdata);
   assign req_tready = !clearing && !queue_full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      push_cmd.kind       = cpa_pkg::CMD_REJECT;
      push_cmd.status     = cpa_pkg::ST_OK;
      push_cmd.page_count = payload.page_count;
      push_cmd.page_index = payload.page_index;
      push_cmd.owner_id   = payload.owner_id;
      if (req_tuser == cpa_pkg::OP_ALLOC) begin
         if (payload.page_count == '0) begin
            push_cmd.status = cpa_pkg::ST_NOSPACE;
         end else begin
            push_cmd.kind = cpa_pkg::CMD_ALLOC;
         end
      end else begin
         if ({1'b0, payload.page_index} < boundary) begin
            push_cmd.status = cpa_pkg::ST_RESERVED;
         end else if (32'(payload.page_index) >= 32'(TOTAL_FRAMES)) begin
            push_cmd.status = cpa_pkg::ST_NOTALLOC;
         end else begin
            push_cmd.kind = cpa_pkg::CMD_FREE;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/cpa_back.sv
// Back part: clears the frame map after reset, runs first-fit searches,
// marks and releases runs and holds the result register. Depends on cpa_pkg.
`default_nettype none

module cpa_back #(
   parameter int TOTAL_FRAMES = cpa_pkg::TOTAL_FRAMES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [10:0]                     boundary,
   input  wire cpa_pkg::cmd_type                q_head,
   input  wire logic                            q_empty,
   output logic                                 q_pop,
   output logic                                 clearing,
   output logic                                 ram_we,
   output logic [$clog2(TOTAL_FRAMES)-1:0]      ram_waddr,
   output cpa_pkg::frame_type                   ram_wdata,
   output logic [$clog2(TOTAL_FRAMES)-1:0]      ram_raddr,
   input  wire cpa_pkg::frame_type              ram_rdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [23:0]                          rsp_tdata,
   output logic [1:0]                           rsp_tuser
);

   localparam int AW = $clog2(TOTAL_FRAMES);
   localparam logic [AW:0] TOT  = (AW + 1)'(TOTAL_FRAMES);
   localparam logic [AW:0] LAST = (AW + 1)'(TOTAL_FRAMES - 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_MARK  = 3'd3;
   localparam logic [2:0] S_FCHK  = 3'd4;
   localparam logic [2:0] S_FWALK = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [AW:0]      addr_ff, addr_in;
   logic [AW:0]      daddr_ff, daddr_in;
   logic [AW:0]      run_ff, run_in;
   logic             pend_ff, pend_in;
   logic [10:0]      rem_ff, rem_in;
   cpa_pkg::cmd_type cmd_ff, cmd_in;
   logic [1:0]       status_ff, status_in;
   logic [9:0]       first_ff, first_in;
   logic [10:0]      alloc_ff, alloc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [9:0]       rsp_first_ff, rsp_first_in;
   logic [10:0]      rsp_used_ff, rsp_used_in;

   logic             issue;
   logic [AW:0]      run_start;
   logic [11:0]      alloc_sum;
   logic [11:0]      used_sum;
   logic [10:0]      alloc_dec;

   cpa_pkg::rsp_payload_type rsp_payload;

   assign clearing  = (state_ff == S_CLEAR);
   assign run_start = daddr_ff + 1'b1 - (AW + 1)'(cmd_ff.page_count);
   assign alloc_sum = {1'b0, alloc_ff} + {1'b0, cmd_ff.page_count};
   assign used_sum  = {1'b0, alloc_ff} + {1'b0, boundary};
   assign alloc_dec = (alloc_ff != '0) ? alloc_ff - 1'b1 : alloc_ff;

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      daddr_in      = daddr_ff;
      run_in        = run_ff;
      pend_in       = pend_ff;
      rem_in        = rem_ff;
      cmd_in        = cmd_ff;
      status_in     = status_ff;
      first_in      = first_ff;
      alloc_in      = alloc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_used_in   = rsp_used_ff;
      q_pop         = 1'b0;
      issue         = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = addr_ff[AW-1:0];
      ram_wdata     = '0;
      ram_raddr     = addr_ff[AW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            if (addr_ff == LAST) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               first_in = '0;
               unique case (q_head.kind)
                  cpa_pkg::CMD_ALLOC: begin
                     addr_in  = (AW + 1)'(boundary);
                     run_in   = '0;
                     pend_in  = 1'b0;
                     state_in = S_SCAN;
                  end
                  cpa_pkg::CMD_FREE: begin
                     ram_raddr = AW'(q_head.page_index);
                     daddr_in  = (AW + 1)'(q_head.page_index);
                     addr_in   = (AW + 1)'(q_head.page_index) + 1'b1;
                     state_in  = S_FCHK;
                  end
                  default: begin
                     status_in = q_head.status;
                     state_in  = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN: begin
            issue    = (addr_ff < TOT);
            pend_in  = issue;
            daddr_in = addr_ff;
            if (issue) begin
               addr_in = addr_ff + 1'b1;
            end
            if (pend_ff) begin
               if (ram_rdata.taken) begin
                  run_in = '0;
               end else if (32'(run_ff) + 32'd1 == 32'(cmd_ff.page_count)) begin
                  first_in = 10'(run_start);
                  addr_in  = run_start;
                  rem_in   = cmd_ff.page_count;
                  pend_in  = 1'b0;
                  alloc_in = alloc_sum[11] ? cpa_pkg::USED_MAX : alloc_sum[10:0];
                  state_in = S_MARK;
               end else begin
                  run_in = run_ff + 1'b1;
               end
            end else if (!issue) begin
               status_in = cpa_pkg::ST_NOSPACE;
               first_in  = '0;
               state_in  = S_RESP;
            end
         end
         S_MARK: begin
            ram_we               = 1'b1;
            ram_wdata.taken      = 1'b1;
            ram_wdata.run_length = cmd_ff.page_count;
            ram_wdata.owner_id   = cmd_ff.owner_id;
            addr_in              = addr_ff + 1'b1;
            rem_in               = rem_ff - 1'b1;
            if (rem_ff == 11'd1) begin
               status_in = cpa_pkg::ST_OK;
               state_in  = S_RESP;
            end
         end
         S_FCHK: begin
            if (!ram_rdata.taken) begin
               status_in = cpa_pkg::ST_NOTALLOC;
               state_in  = S_RESP;
            end else if (ram_rdata.run_length == '0) begin
               status_in = cpa_pkg::ST_OK;
               state_in  = S_RESP;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = daddr_ff[AW-1:0];
               alloc_in  = alloc_dec;
               rem_in    = ram_rdata.run_length - 1'b1;
               pend_in   = 1'b0;
               state_in  = S_FWALK;
            end
         end
         S_FWALK: begin
            issue    = (rem_ff != '0) && (addr_ff < TOT);
            pend_in  = issue;
            daddr_in = addr_ff;
            if (issue) begin
               addr_in = addr_ff + 1'b1;
               rem_in  = rem_ff - 1'b1;
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = daddr_ff[AW-1:0];
               if (ram_rdata.taken) begin
                  alloc_in = alloc_dec;
               end
            end else if (!issue) begin
               status_in = cpa_pkg::ST_OK;
               state_in  = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_first_in  = first_ff;
               rsp_used_in   = used_sum[11] ? cpa_pkg::USED_MAX : used_sum[10:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         alloc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      daddr_ff      <= daddr_in;
      run_ff        <= run_in;
      rem_ff        <= rem_in;
      cmd_ff        <= cmd_in;
      status_ff     <= status_in;
      first_ff      <= first_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_used_ff   <= rsp_used_in;
   end

   always_comb begin
      rsp_payload             = '0;
      rsp_payload.first_frame = rsp_first_ff;
      rsp_payload.used_pages  = rsp_used_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_payload;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

// File: rtl/contiguous_page_allocator.sv
// First-fit contiguous page frame allocator, top level.
// Depends on cpa_pkg, cpa_front, cpa_cmd_queue, cpa_back and cpa_ram.
//
// Requests arrive on the req_ stream: tuser selects allocate or free, tdata
// carries the page count, page index and owner. Each request gives exactly one
// beat on the rsp_ stream: tuser is the status, tdata the first frame and the
// used page count. The csr_ port writes the reserved boundary, which the user
// must write only while idle; the block does not enforce this. A rejected
// request (zero count, reserved or out-of-map index) answers without a walk
// of the frame map. An allocate scans frames upward from the boundary for the
// first free run, then writes the run; a free checks the frame at its index
// and clears the run from there. The frame map RAM has one read and one write
// port and is walked one frame per cycle; one request is worked on at a time.
// A two-entry command queue takes new requests while one is in progress.
// After reset the map is cleared with req_tready low.
// A result waiting on rsp_tready stays in the output register while the next
// request runs; that request then waits for the register to free up.
`default_nettype none

module contiguous_page_allocator #(
   parameter int TOTAL_FRAMES = cpa_pkg::TOTAL_FRAMES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // page_count[10:0], page_index[20:11], owner_id[36:21]
   input  wire logic        req_tuser,   // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // first_frame[9:0], used_pages[20:10]
   output logic [1:0]       rsp_tuser,   // status
   input  wire logic        csr_we,
   input  wire logic [10:0] csr_wdata
);

   localparam int AW = $clog2(TOTAL_FRAMES);

   logic [10:0]        reserved_ff;
   logic [10:0]        boundary;
   logic               clearing;
   logic               q_full;
   logic               q_empty;
   logic               q_push;
   logic               q_pop;
   cpa_pkg::cmd_type   push_cmd;
   cpa_pkg::cmd_type   q_head;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [AW-1:0]      ram_raddr;
   cpa_pkg::frame_type ram_wdata;
   cpa_pkg::frame_type ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
      end else if (csr_we) begin
         reserved_ff <= csr_wdata;
      end
   end

   assign boundary = (32'(reserved_ff) > 32'(TOTAL_FRAMES)) ? 11'(TOTAL_FRAMES) : reserved_ff;

   cpa_front #(
      .TOTAL_FRAMES(TOTAL_FRAMES)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .boundary   (boundary),
      .clearing   (clearing),
      .queue_full (q_full),
      .push       (q_push),
      .push_cmd   (push_cmd)
   );

   cpa_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   cpa_back #(
      .TOTAL_FRAMES(TOTAL_FRAMES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .boundary   (boundary),
      .q_head     (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   cpa_ram #(
      .WIDTH($bits(cpa_pkg::frame_type)),
      .DEPTH(TOTAL_FRAMES)
   ) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire

// File: rtl/cpa_checker.sv
// Port-level checks of the contiguous page allocator, bound to the top level.
// Depends on cpa_pkg and contiguous_page_allocator_defines.svh.
`default_nettype none
`include "contiguous_page_allocator_defines.svh"

module cpa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   `CPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "Stalled response beat changed or dropped.")

   `CPA_ASSERT_SAME(a_fail_first_zero, clock, reset, rsp_tvalid && (rsp_tuser != cpa_pkg::ST_OK), rsp_tdata[9:0] == 10'd0, "Failed request reported a nonzero first frame.")

   `CPA_ASSERT_NEXT_NR(a_reset_quiet, clock, reset, !req_tready && !rsp_tvalid, "Block not quiet in the cycle after reset.")

endmodule

bind contiguous_page_allocator cpa_checker u_cpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench for contiguous_page_allocator: directed and random allocate/free requests.
// Uses cpa_pkg and the RTL top; a frame-map scoreboard predicts every result beat.

module tb;

   localparam int FRAMES = cpa_pkg::TOTAL_FRAMES_DEFAULT;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  first_frame;
      logic [10:0] used_pages;
   } page_result_type;

   class frame_map_scoreboard;
      bit              taken[FRAMES];
      bit [10:0]       run_length[FRAMES];
      bit [15:0]       owner[FRAMES];
      int              allocated;
      bit [10:0]       boundary_reg;
      page_result_type pending[$];
      int              errors;
      int              checked;

      function page_result_type note_request(logic op, logic [10:0] count, logic [9:0] index,
                                             logic [15:0] owner_id);
         page_result_type res;
         int lim;
         int run;
         int first;
         int last;
         int i;
         bit found;
         lim = (boundary_reg > FRAMES) ? FRAMES : boundary_reg;
         res.status = cpa_pkg::ST_OK;
         first = 0;
         if (op == cpa_pkg::OP_ALLOC) begin
            run = 0;
            found = 1'b0;
            if (count != 0) begin
               for (i = lim; i < FRAMES && !found; i++) begin
                  if (!taken[i]) begin
                     run++;
                     if (run == count) begin
                        found = 1'b1;
                        first = i + 1 - count;
                     end
                  end else begin
                     run = 0;
                  end
               end
            end
            if (!found) begin
               res.status = cpa_pkg::ST_NOSPACE;
               first = 0;
            end else begin
               for (i = first; i < first + count; i++) begin
                  taken[i] = 1'b1;
                  run_length[i] = count;
                  owner[i] = owner_id;
               end
               allocated = allocated + count;
               if (allocated > cpa_pkg::USED_MAX) allocated = cpa_pkg::USED_MAX;
            end
         end else begin
            if (index < lim) begin
               res.status = cpa_pkg::ST_RESERVED;
            end else if (!taken[index]) begin
               res.status = cpa_pkg::ST_NOTALLOC;
            end else begin
               last = index + run_length[index];
               if (last > FRAMES) last = FRAMES;
               for (i = index; i < last; i++) begin
                  if (taken[i] && allocated > 0) allocated--;
                  taken[i] = 1'b0;
                  run_length[i] = '0;
                  owner[i] = '0;
               end
            end
            first = 0;
         end
         res.first_frame = first[9:0];
         res.used_pages = (lim + allocated > cpa_pkg::USED_MAX) ? cpa_pkg::USED_MAX
                                                                : 11'(lim + allocated);
         pending.push_back(res);
         return res;
      endfunction

      function void check_result(logic [1:0] status, logic [23:0] data);
         page_result_type want;
         cpa_pkg::rsp_payload_type got;
         got = data;
         if (pending.size() == 0) begin
            $error("result beat with no request outstanding: status %0d data 0x%06h",
                   status, data);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
         end
         if (got.first_frame !== want.first_frame) begin
            $error("first_frame: expected %0d, got %0d", want.first_frame, got.first_frame);
            errors++;
         end
         if (got.used_pages !== want.used_pages) begin
            $error("used_pages: expected %0d, got %0d", want.used_pages, got.used_pages);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // page_count[10:0], page_index[20:11], owner_id[36:21]
   logic        req_tuser = 1'b0; // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // first_frame[9:0], used_pages[20:10]
   logic [1:0]  rsp_tuser;        // status
   logic        csr_we = 1'b0;
   logic [10:0] csr_wdata = '0;

   frame_map_scoreboard sb = new;
   int unsigned         live_starts[$];
   int                  send_idle_pct = 28;
   int                  recv_idle_pct = 88;
   int                  n_alloc = 0;
   int                  n_free = 0;

   contiguous_page_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
      rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic send_request(input logic op, input logic [10:0] count,
                               input logic [9:0] index, input logic [15:0] owner_id);
      cpa_pkg::req_payload_type payload;
      page_result_type expected;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      payload = '0;
      payload.page_count = count;
      payload.page_index = index;
      payload.owner_id = owner_id;
      req_tvalid <= 1'b1;
      req_tdata <= payload;
      req_tuser <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected = sb.note_request(op, count, index, owner_id);
      if (op == cpa_pkg::OP_ALLOC) begin
         n_alloc++;
         if (expected.status == cpa_pkg::ST_OK) begin
            live_starts.push_back({22'd0, expected.first_frame});
         end
      end else begin
         n_free++;
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_boundary(input logic [10:0] value);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.boundary_reg = value;
   endtask

   function automatic logic [10:0] pick_alloc_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return 11'($urandom_range(1, 8));
      if (roll < 93) return 11'($urandom_range(9, 64));
      if (roll < 98) return 11'($urandom_range(65, 512));
      return 11'($urandom_range(0, 2047));
   endfunction

   task automatic run_random_phase(input int items);
      int unsigned still_live[$];
      int k;
      int i;
      int pick;
      int free_pct;
      logic [9:0] index;
      for (k = 0; k < items; k++) begin
         still_live.delete();
         for (i = 0; i < live_starts.size(); i++) begin
            if (sb.taken[live_starts[i]]) still_live.push_back(live_starts[i]);
         end
         live_starts = still_live;
         if ($urandom_range(0, 99) < 2) drain_results();
         free_pct = (live_starts.size() > 40) ? 65 : 35;
         if ($urandom_range(0, 99) < free_pct) begin
            if (live_starts.size() != 0 && $urandom_range(0, 99) < 80) begin
               pick = $urandom_range(0, live_starts.size() - 1);
               index = 10'(live_starts[pick]);
               live_starts.delete(pick);
            end else begin
               index = 10'($urandom_range(0, FRAMES - 1));
            end
            send_request(cpa_pkg::OP_FREE, 11'($urandom_range(0, 2047)), index,
                         16'($urandom_range(0, 65535)));
         end else begin
            send_request(cpa_pkg::OP_ALLOC, pick_alloc_count(),
                         10'($urandom_range(0, FRAMES - 1)),
                         16'($urandom_range(0, 65535)));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty map: zero count, whole map, full map, double free, oversized request.
      send_request(cpa_pkg::OP_ALLOC, 11'd0, 10'd1023, 16'hFFFF);
      send_request(cpa_pkg::OP_ALLOC, 11'd1024, 10'd0, 16'hFFFF);
      send_request(cpa_pkg::OP_ALLOC, 11'd1, 10'd0, 16'h0000);
      send_request(cpa_pkg::OP_FREE, 11'd2047, 10'd0, 16'h0000);
      send_request(cpa_pkg::OP_FREE, 11'd0, 10'd0, 16'hFFFF);
      send_request(cpa_pkg::OP_FREE, 11'd5, 10'd1023, 16'h1234);
      send_request(cpa_pkg::OP_ALLOC, 11'd2047, 10'd512, 16'h0000);
      // A run that ends at the top frame, then a free from inside a run past the map end.
      send_request(cpa_pkg::OP_ALLOC, 11'd1000, 10'd0, 16'h0000);
      send_request(cpa_pkg::OP_ALLOC, 11'd24, 10'd1023, 16'hFFFF);
      send_request(cpa_pkg::OP_ALLOC, 11'd1, 10'd0, 16'hA5A5);
      send_request(cpa_pkg::OP_FREE, 11'd0, 10'd500, 16'h0000);
      send_request(cpa_pkg::OP_FREE, 11'd0, 10'd1000, 16'h0000);
      // The next free clears a span that holds both taken and free frames.
      send_request(cpa_pkg::OP_ALLOC, 11'd10, 10'd0, 16'h5A5A);
      send_request(cpa_pkg::OP_FREE, 11'd0, 10'd0, 16'h0000);
      send_request(cpa_pkg::OP_ALLOC, 11'd3, 10'd0, 16'h0001);

      write_boundary(11'd1024);
      send_request(cpa_pkg::OP_ALLOC, 11'd1, 10'd0, 16'h0002);
      send_request(cpa_pkg::OP_FREE, 11'd0, 10'd0, 16'h0000);
      send_request(cpa_pkg::OP_FREE, 11'd0, 10'd1023, 16'h0000);
      write_boundary(11'd2047);
      send_request(cpa_pkg::OP_ALLOC, 11'd5, 10'd0, 16'h0003);
      send_request(cpa_pkg::OP_FREE, 11'd0, 10'd512, 16'h0000);
      write_boundary(11'd3);
      send_request(cpa_pkg::OP_FREE, 11'd0, 10'd0, 16'h0000);
      send_request(cpa_pkg::OP_FREE, 11'd0, 10'd3, 16'h0000);
      send_request(cpa_pkg::OP_ALLOC, 11'd1, 10'd0, 16'h0004);

      write_boundary(11'd0);
      run_random_phase(185);
      send_idle_pct = 88;
      recv_idle_pct = 28;
      write_boundary(11'($urandom_range(200, 800)));
      run_random_phase(185);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_boundary(11'($urandom_range(1, 100)));
      run_random_phase(185);

      drain_results();
      repeat (100) @(posedge clock);
      $display("Ran %0d allocate and %0d free requests; %0d result beats checked.",
               n_alloc, n_free, sb.checked);
      $display("Boundary settings spanned 0, 3, 1024, 2047 and two random values.");
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $error("run did not finish in time");
      $display("FAIL");
      $finish;
   end

endmodule
